@@ rtl/gmts_pkg.sv @@
`default_nettype none
package gmts_pkg;

   localparam int MAX_LEVELS  = 16;
   localparam int LVL_W       = 4;
   localparam int TEXEL_DEPTH = 131072;
   localparam int ADDR_W      = 17;
   localparam int DIM_W       = 9;
   localparam int IDX_W       = 8;
   localparam int MAX_DIM     = 256;
   localparam int DIV_NUM_W   = 34;
   localparam int DIV_CNT_W   = 6;
   localparam int ACC_W       = 64;

   localparam logic [15:0] RAD_THRESH  = 16'd53020;
   localparam logic [15:0] INV_PHI_Q16 = 16'd40503;
   localparam logic [17:0] BLEND_GAIN  = 18'd212079;
   localparam logic [16:0] ONE_Q16     = 17'd65536;

   typedef enum logic [1:0] {
      CMD_WRITE_TEXEL = 2'd0,
      CMD_WRITE_LEVEL = 2'd1,
      CMD_SAMPLE      = 2'd2,
      CMD_NONE        = 2'd3
   } command_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SEARCH,
      ST_WEIGHT,
      ST_LEVEL,
      ST_DIV,
      ST_MAP,
      ST_ADDR,
      ST_WFULL,
      ST_MUL,
      ST_ACC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  level;
      logic [16:0] address;
      logic [15:0] texel_red;
      logic [15:0] texel_green;
      logic [15:0] texel_blue;
      logic [8:0]  level_width;
      logic [8:0]  level_height;
      logic [15:0] sample_x;
      logic [15:0] sample_y;
      logic [15:0] radius;
   } req_payload_type;

   typedef struct packed {
      logic        ok;
      logic [15:0] out_red;
      logic [15:0] out_green;
      logic [15:0] out_blue;
   } rsp_payload_type;

   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [DIM_W-1:0]  width;
      logic [DIM_W-1:0]  height;
   } level_desc_type;

endpackage
`default_nettype wire

@@ rtl/gmts_div.sv @@
`default_nettype none
module gmts_div import gmts_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DIV_NUM_W-1:0] num,
   input  wire logic [DIM_W-1:0]     den,
   output logic                      busy,
   output logic [DIV_NUM_W-1:0]      quot
);

   logic [DIV_NUM_W-1:0] quot_ff;
   logic [DIM_W-1:0]     rem_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic [DIM_W:0]       trial;
   logic                 take;

   // trial subtract of one quotient bit
   always_comb begin
      trial = {rem_ff, quot_ff[DIV_NUM_W-1]};
      take  = trial >= {1'b0, den};
   end

   // control: count one bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= DIV_CNT_W'(DIV_NUM_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // datapath: shift numerator out, quotient in
   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= num;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         quot_ff <= {quot_ff[DIV_NUM_W-2:0], take};
         rem_ff  <= take ? DIM_W'(trial - {1'b0, den}) : trial[DIM_W-1:0];
      end
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire

@@ rtl/golden_mipmap_trilinear_sampler_core.sv @@
`default_nettype none
// Trilinear sampler over a golden-ratio MIP pyramid.
// Input channel (req_valid/req_stall/req_payload): one command per beat.
// Texel writes and level descriptor writes give no result.
// A sample command gives one beat on the result channel (rsp_valid/rsp_stall).
// A sample runs a range check, a radius search that steps one level at a
// time, a weight step, then for each of the two levels with a nonzero weight
// level setup, coordinate division (one quotient bit per cycle) and mapping,
// plus 4 taps, each one texel memory read, two weight products, then one
// 16x24 or 16x25 product and one accumulate per channel half.
// An out-of-range sample skips the search, the weights and both levels and
// goes straight to the result. The block works on one sample at a time;
// req_stall is high from acceptance until the result is loaded into the
// output register. A held result does not block the next command: req_stall
// drops as soon as the result sits in the output register, even while
// rsp_stall holds it. Reset clears control and sets level_count to 2; texel
// memory and level table are undefined until written. The csr channel
// (csr_valid/csr_ready) writes level_count and is always ready.
module golden_mipmap_trilinear_sampler_core import gmts_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_payload,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [4:0]      csr_data
);

   typedef struct packed {
      logic [IDX_W-1:0] i0;
      logic [IDX_W-1:0] i1;
      logic [16:0]      f;
   } axis_map_type;

   function automatic axis_map_type map_axis(input logic [DIV_NUM_W-1:0] a,
                                             input logic [DIM_W-1:0] size);
      axis_map_type         m;
      logic [DIV_NUM_W-1:0] v;
      logic [DIV_NUM_W-1:0] vr;
      logic [DIM_W-1:0]     top;
      top = size - 2'd2;
      v   = a - DIV_NUM_W'(32768);
      vr  = v - {top, 16'b0};
      m   = '0;
      if (size < DIM_W'(2)) begin
         m = '0;
      end else if (a <= DIV_NUM_W'(32768)) begin
         m.i0 = '0;
         m.f  = '0;
         m.i1 = IDX_W'(1);
      end else if (v[DIV_NUM_W-1:16] >= (DIV_NUM_W-16)'(top)) begin
         m.i0 = top[IDX_W-1:0];
         m.i1 = top[IDX_W-1:0] + 1'b1;
         m.f  = (vr > DIV_NUM_W'(ONE_Q16)) ? ONE_Q16 : vr[16:0];
      end else begin
         m.i0 = v[16+IDX_W-1:16];
         m.i1 = v[16+IDX_W-1:16] + 1'b1;
         m.f  = {1'b0, v[15:0]};
      end
      return m;
   endfunction

   state_type state_ff, state_in;

   logic [47:0]       texel_mem [TEXEL_DEPTH];
   logic [47:0]       texel_rd_ff;
   level_desc_type    level_tab_ff [MAX_LEVELS];
   logic [4:0]        level_count_ff;

   logic [15:0]       sx_ff, sy_ff;
   logic [23:0]       r_ff;
   logic [LVL_W-1:0]  mi_ff;
   logic              k_ff;
   logic [16:0]       wt0_ff, wt1_ff;
   level_desc_type    cur_ff;
   axis_map_type      mx_ff, my_ff;
   logic [1:0]        tap_ff;
   logic [32:0]       wxy_ff;
   logic [48:0]       wfull_ff;
   logic [1:0]        ch_ff;
   logic              half_ff;
   logic [40:0]       prod_ff;
   logic [ACC_W-1:0]  acc_ff [3];
   logic              ok_ff;

   logic              rsp_valid_ff;
   rsp_payload_type   rsp_ff;

   logic [4:0]        n_lvl;
   logic              search_go;
   logic              out_range;
   logic [39:0]       r_mul;
   logic [33:0]       w_mul;
   logic [17:0]       w_rnd;
   logic [16:0]       wt_cur;
   level_desc_type    sel_desc;
   logic [16:0]       pos_x, pos_y;
   logic [DIV_NUM_W-1:0] num_x, num_y;
   logic              start_div;
   logic              busy_x, busy_y;
   logic [DIV_NUM_W-1:0] quot_x, quot_y;
   logic [IDX_W-1:0]  tx, ty;
   logic [16:0]       wx, wy;
   logic [ADDR_W-1:0] rd_addr;
   logic [15:0]       tex_c;
   logic              out_free;
   logic              accept;
   logic              last_step;
   logic [17:0]       rnd [3];

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // clamp loaded level count to 2..MAX_LEVELS
   always_comb begin
      if (level_count_ff < 5'd2) begin
         n_lvl = 5'd2;
      end else if (level_count_ff > 5'(MAX_LEVELS)) begin
         n_lvl = 5'(MAX_LEVELS);
      end else begin
         n_lvl = level_count_ff;
      end
   end

   // level search and blend weight arithmetic
   always_comb begin
      search_go = (({1'b0, mi_ff} + 5'd2) < n_lvl) && (r_ff >= {8'b0, RAD_THRESH});
      out_range = ({8'b0, sx_ff} >= {level_tab_ff[0].width, 8'b0}) ||
                  ({8'b0, sy_ff} >= {level_tab_ff[0].height, 8'b0});
      r_mul     = r_ff * INV_PHI_Q16 + 40'd32768;
      w_mul     = (RAD_THRESH - r_ff[15:0]) * BLEND_GAIN + 34'd32768;
      w_rnd     = w_mul[33:16];
      wt_cur    = k_ff ? wt1_ff : wt0_ff;
      sel_desc  = level_tab_ff[mi_ff + LVL_W'(k_ff)];
   end

   // divider numerators: size * (pos + 128) << 8
   always_comb begin
      pos_x = {1'b0, sx_ff} + 17'd128;
      pos_y = {1'b0, sy_ff} + 17'd128;
      num_x = DIV_NUM_W'(sel_desc.width * {9'b0, pos_x}) << 8;
      num_y = DIV_NUM_W'(sel_desc.height * {9'b0, pos_y}) << 8;
      start_div = (state_ff == ST_LEVEL) && (wt_cur != '0);
   end

   gmts_div u_div_x (
      .clock (clock),
      .reset (reset),
      .start (start_div),
      .num   (num_x),
      .den   (level_tab_ff[0].width),
      .busy  (busy_x),
      .quot  (quot_x)
   );

   gmts_div u_div_y (
      .clock (clock),
      .reset (reset),
      .start (start_div),
      .num   (num_y),
      .den   (level_tab_ff[0].height),
      .busy  (busy_y),
      .quot  (quot_y)
   );

   // tap address and bilinear weights
   always_comb begin
      tx      = tap_ff[0] ? mx_ff.i1 : mx_ff.i0;
      ty      = tap_ff[1] ? my_ff.i1 : my_ff.i0;
      wx      = tap_ff[0] ? mx_ff.f : ONE_Q16 - mx_ff.f;
      wy      = tap_ff[1] ? my_ff.f : ONE_Q16 - my_ff.f;
      rd_addr = ADDR_W'(cur_ff.base + ty * cur_ff.width + {9'b0, tx});
      tex_c   = texel_rd_ff[{ch_ff, 4'b0} +: 16];
      last_step = half_ff && (ch_ff == 2'd2);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_payload.command == CMD_SAMPLE) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK:  state_in = out_range ? ST_DONE : ST_SEARCH;
         ST_SEARCH: state_in = search_go ? ST_SEARCH : ST_WEIGHT;
         ST_WEIGHT: state_in = ST_LEVEL;
         ST_LEVEL: begin
            if (wt_cur != '0) begin
               state_in = ST_DIV;
            end else if (k_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DIV:   state_in = (!busy_x && !busy_y) ? ST_MAP : ST_DIV;
         ST_MAP:   state_in = ST_ADDR;
         ST_ADDR:  state_in = ST_WFULL;
         ST_WFULL: state_in = ST_MUL;
         ST_MUL:   state_in = ST_ACC;
         ST_ACC: begin
            if (!last_step) begin
               state_in = ST_MUL;
            end else if (tap_ff != 2'd3) begin
               state_in = ST_ADDR;
            end else begin
               state_in = k_ff ? ST_DONE : ST_LEVEL;
            end
         end
         ST_DONE:  state_in = out_free ? ST_IDLE : ST_DONE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs of the control
   always_comb begin
      req_stall = state_ff != ST_IDLE;
      csr_ready = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         level_count_ff <= 5'd2;
      end else if (csr_valid && csr_ready) begin
         level_count_ff <= csr_data;
      end
   end

   // texel memory: write on texel command, read one tap at a time
   always_ff @(posedge clock) begin
      if (accept && req_payload.command == CMD_WRITE_TEXEL) begin
         texel_mem[req_payload.address] <= {req_payload.texel_blue,
                                            req_payload.texel_green,
                                            req_payload.texel_red};
      end
      if (state_ff == ST_ADDR) begin
         texel_rd_ff <= texel_mem[rd_addr];
      end
   end

   // level table: saturate sizes on write
   always_ff @(posedge clock) begin
      if (accept && req_payload.command == CMD_WRITE_LEVEL) begin
         level_tab_ff[req_payload.level].base   <= req_payload.address;
         level_tab_ff[req_payload.level].width  <=
            (req_payload.level_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                        : req_payload.level_width;
         level_tab_ff[req_payload.level].height <=
            (req_payload.level_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                         : req_payload.level_height;
      end
   end

   // sample datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            sx_ff     <= req_payload.sample_x;
            sy_ff     <= req_payload.sample_y;
            r_ff      <= {req_payload.radius, 8'b0};
            mi_ff     <= '0;
            k_ff      <= 1'b0;
            acc_ff[0] <= '0;
            acc_ff[1] <= '0;
            acc_ff[2] <= '0;
         end
         ST_CHECK: ok_ff <= !out_range;
         ST_SEARCH: begin
            if (search_go) begin
               r_ff  <= r_mul[39:16];
               mi_ff <= mi_ff + 1'b1;
            end
         end
         ST_WEIGHT: begin
            if (r_ff >= {8'b0, RAD_THRESH}) begin
               wt0_ff <= '0;
               wt1_ff <= ONE_Q16;
            end else begin
               wt0_ff <= (w_rnd > {1'b0, ONE_Q16}) ? ONE_Q16 : w_rnd[16:0];
               wt1_ff <= (w_rnd > {1'b0, ONE_Q16}) ? '0 : ONE_Q16 - w_rnd[16:0];
            end
         end
         ST_LEVEL: begin
            cur_ff <= sel_desc;
            tap_ff <= '0;
            if (wt_cur == '0) begin
               k_ff <= 1'b1;
            end
         end
         ST_DIV: ;
         ST_MAP: begin
            mx_ff <= map_axis(quot_x, cur_ff.width);
            my_ff <= map_axis(quot_y, cur_ff.height);
         end
         ST_ADDR: begin
            wxy_ff  <= wx * wy;
            ch_ff   <= '0;
            half_ff <= 1'b0;
         end
         ST_WFULL: wfull_ff <= wxy_ff * wt_cur;
         ST_MUL: begin
            prod_ff <= half_ff ? tex_c * wfull_ff[48:24]
                               : 41'(tex_c * wfull_ff[23:0]);
         end
         ST_ACC: begin
            acc_ff[ch_ff] <= acc_ff[ch_ff] +
                             (half_ff ? {prod_ff[39:0], 24'b0} : ACC_W'(prod_ff));
            half_ff <= !half_ff;
            if (half_ff) begin
               ch_ff <= ch_ff + 1'b1;
            end
            if (last_step) begin
               tap_ff <= tap_ff + 1'b1;
               if (tap_ff == 2'd3) begin
                  k_ff <= 1'b1;
               end
            end
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   // round half up to 16 bits
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rnd[c] = {1'b0, acc_ff[c][ACC_W-1:47]} + 18'd1;
      end
   end

   // result register: load when free, hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_ff.ok        <= ok_ff;
         rsp_ff.out_red   <= ok_ff ? rnd[0][16:1] : '0;
         rsp_ff.out_green <= ok_ff ? rnd[1][16:1] : '0;
         rsp_ff.out_blue  <= ok_ff ? rnd[2][16:1] : '0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire
